// ----- rtl/websocket_frame_receiver_unit_defines.svh -----
// Assertion macros used by the receiver front end (wfr_front).
`ifndef WEBSOCKET_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define WFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define WFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define WFR_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define WFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/wfr_pkg.sv -----
`timescale 1ns / 1ps

package wfr_pkg;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_MASK    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CLOSED  = 6'b100000
	} phase_t;

	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_PONG    = 2'd1;
	localparam logic [1:0] EV_CLOSE   = 2'd2;

	localparam logic [3:0] RSN_FIN_CLEAR = 4'd0;
	localparam logic [3:0] RSN_RESERVED  = 4'd1;
	localparam logic [3:0] RSN_PEER      = 4'd2;
	localparam logic [3:0] RSN_PONG      = 4'd3;
	localparam logic [3:0] RSN_BAD_OP    = 4'd4;
	localparam logic [3:0] RSN_UNMASKED  = 4'd5;
	localparam logic [3:0] RSN_EMPTY     = 4'd6;
	localparam logic [3:0] RSN_ZERO_EXT  = 4'd7;
	localparam logic [3:0] RSN_TOO_LONG  = 4'd8;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'ha;

	localparam logic [7:0] FIN_BIT   = 8'h80;
	localparam logic [7:0] RSV_BITS  = 8'h70;
	localparam logic [7:0] OP_BITS   = 8'h0f;
	localparam logic [7:0] MASK_BIT  = 8'h80;
	localparam logic [7:0] LEN_BITS  = 8'h7f;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;
	localparam logic        REG_MAX_LEN = 1'b0;
	localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
		logic [3:0] reason;
	} cmd_t;

endpackage

// ----- rtl/wfr_front.sv -----
`timescale 1ns / 1ps
`include "websocket_frame_receiver_unit_defines.svh"

module wfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          rx_byte,
	input  logic                full,
	input  logic [31:0]         max_len,
	output logic                push,
	output wfr_pkg::cmd_t       cmd
);

	wfr_pkg::phase_t phase_q, phase_n;
	logic        ping_q, ping_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [31:0] len_q, len_n;
	logic        ovf_q, ovf_n;
	logic [31:0] key_q, key_n;
	logic [31:0] rem_q, rem_n;
	logic [1:0]  idx_q, idx_n;
	logic        accept;
	logic [3:0]  op;
	logic [31:0] len_shift;
	logic [7:0]  key_byte;

	assign accept    = in_valid && !full;
	assign op        = rx_byte[3:0] & wfr_pkg::OP_BITS[3:0];
	assign len_shift = {len_q[23:0], rx_byte};

	always_comb begin
		case (idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		ping_n  = ping_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		ovf_n   = ovf_q;
		key_n   = key_q;
		rem_n   = rem_q;
		idx_n   = idx_q;
		push    = 1'b0;
		cmd     = '0;
		if (accept) begin
			case (phase_q)
				wfr_pkg::PH_HDR0: begin
					push = 1'b1;
					cmd.kind = wfr_pkg::EV_CLOSE;
					phase_n = wfr_pkg::PH_CLOSED;
					if ((rx_byte & wfr_pkg::FIN_BIT) == 8'h00) begin
						cmd.reason = wfr_pkg::RSN_FIN_CLEAR;
					end else if ((rx_byte & wfr_pkg::RSV_BITS) != 8'h00) begin
						cmd.reason = wfr_pkg::RSN_RESERVED;
					end else begin
						case (op)
							wfr_pkg::OP_TEXT: begin
								push = 1'b0;
								cmd.kind = wfr_pkg::EV_PAYLOAD;
								ping_n = 1'b0;
								phase_n = wfr_pkg::PH_HDR1;
							end
							wfr_pkg::OP_CLOSE: cmd.reason = wfr_pkg::RSN_PEER;
							wfr_pkg::OP_PING: begin
								cmd.kind = wfr_pkg::EV_PONG;
								ping_n = 1'b1;
								phase_n = wfr_pkg::PH_HDR1;
							end
							wfr_pkg::OP_PONG: cmd.reason = wfr_pkg::RSN_PONG;
							default: cmd.reason = wfr_pkg::RSN_BAD_OP;
						endcase
					end
				end
				wfr_pkg::PH_HDR1: begin
					ovf_n = 1'b0;
					len_n = '0;
					if ((rx_byte & wfr_pkg::MASK_BIT) == 8'h00) begin
						push = 1'b1;
						cmd.kind = wfr_pkg::EV_CLOSE;
						cmd.reason = wfr_pkg::RSN_UNMASKED;
						phase_n = wfr_pkg::PH_CLOSED;
					end else if (rx_byte[6:0] == wfr_pkg::LEN_EXT16) begin
						cnt_n = 3'd2;
						phase_n = wfr_pkg::PH_EXTLEN;
					end else if (rx_byte[6:0] == wfr_pkg::LEN_EXT64) begin
						cnt_n = 3'd0; // wraps to seven: eight bytes
						phase_n = wfr_pkg::PH_EXTLEN;
					end else if (rx_byte[6:0] == 7'd0 && !ping_q) begin
						push = 1'b1;
						cmd.kind = wfr_pkg::EV_CLOSE;
						cmd.reason = wfr_pkg::RSN_EMPTY;
						phase_n = wfr_pkg::PH_CLOSED;
					end else begin
						len_n = {24'd0, rx_byte & wfr_pkg::LEN_BITS};
						if ({24'd0, rx_byte & wfr_pkg::LEN_BITS} > max_len) begin
							push = 1'b1;
							cmd.kind = wfr_pkg::EV_CLOSE;
							cmd.reason = wfr_pkg::RSN_TOO_LONG;
							phase_n = wfr_pkg::PH_CLOSED;
						end else begin
							key_n = '0;
							idx_n = 2'd0;
							phase_n = wfr_pkg::PH_MASK;
						end
					end
				end
				wfr_pkg::PH_EXTLEN: begin
					len_n = len_shift;
					ovf_n = ovf_q || (len_q[31:24] != 8'h00);
					cnt_n = cnt_q - 3'd1;
					if (cnt_n == 3'd0) begin
						if (len_shift == 32'd0 && !ovf_n) begin
							push = 1'b1;
							cmd.kind = wfr_pkg::EV_CLOSE;
							cmd.reason = wfr_pkg::RSN_ZERO_EXT;
							phase_n = wfr_pkg::PH_CLOSED;
						end else if (ovf_n || len_shift > max_len) begin
							push = 1'b1;
							cmd.kind = wfr_pkg::EV_CLOSE;
							cmd.reason = wfr_pkg::RSN_TOO_LONG;
							phase_n = wfr_pkg::PH_CLOSED;
						end else begin
							key_n = '0;
							idx_n = 2'd0;
							phase_n = wfr_pkg::PH_MASK;
						end
					end
				end
				wfr_pkg::PH_MASK: begin
					key_n = {key_q[23:0], rx_byte};
					idx_n = idx_q + 2'd1;
					if (idx_n == 2'd0) begin
						rem_n = len_q;
						phase_n = (len_q == 32'd0) ? wfr_pkg::PH_HDR0 : wfr_pkg::PH_PAYLOAD;
					end
				end
				wfr_pkg::PH_PAYLOAD: begin
					push = 1'b1;
					cmd.kind = wfr_pkg::EV_PAYLOAD;
					cmd.data = rx_byte;
					cmd.key = key_byte;
					cmd.last = (rem_q == 32'd1);
					idx_n = idx_q + 2'd1;
					rem_n = rem_q - 32'd1;
					if (rem_q == 32'd1) begin
						phase_n = wfr_pkg::PH_HDR0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wfr_pkg::PH_HDR0;
			ping_q  <= 1'b0;
			cnt_q   <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			key_q   <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_n;
			ping_q  <= ping_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			ovf_q   <= ovf_n;
			key_q   <= key_n;
			rem_q   <= rem_n;
			idx_q   <= idx_n;
		end
	end

	`WFR_ASSERT_NEXT(a_closed_sticky, clk, arst_n, phase_q == wfr_pkg::PH_CLOSED,
		phase_q == wfr_pkg::PH_CLOSED)
	`WFR_ASSERT_NEXT(a_close_shuts, clk, arst_n, push && cmd.kind == wfr_pkg::EV_CLOSE,
		phase_q == wfr_pkg::PH_CLOSED)
	`WFR_ASSERT_SAME(a_payload_nonzero, clk, arst_n, phase_q == wfr_pkg::PH_PAYLOAD,
		rem_q != 32'd0)

endmodule

// ----- rtl/wfr_queue.sv -----
`timescale 1ns / 1ps

module wfr_queue #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/wfr_back.sv -----
`timescale 1ns / 1ps

module wfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  wfr_pkg::cmd_t cmd,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    event_kind,
	output logic [7:0]    payload_byte,
	output logic          last_of_message,
	output logic [3:0]    close_reason
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [3:0] reason_q;

	assign pop = !empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= cmd.kind;
			byte_q   <= cmd.data ^ cmd.key;
			last_q   <= cmd.last;
			reason_q <= cmd.reason;
		end
	end

	assign out_valid       = valid_q;
	assign event_kind      = kind_q;
	assign payload_byte    = byte_q;
	assign last_of_message = last_q;
	assign close_reason    = reason_q;

endmodule

// ----- rtl/websocket_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// WebSocket frame receiver: parses and unmasks a received frame stream.
// Input channel: in_valid/in_stall carry one rx_byte per transfer.
// Output channel: out_valid/out_stall carry one event per transfer:
//   a payload byte (with last_of_message), a pong request, or a close
//   with close_reason. Many input bytes (header, length, mask) give none.
// Config: APB-style port, max_message_length at byte address 0.
// Throughput: one byte per cycle while in_stall is low. The parser front end
// updates its state on each accepted byte; events go through a QUEUE_DEPTH
// entry queue to an output register. An event is queued as its byte is taken,
// then popped into the output register. in_stall rises only when the queue
// is full, so a stalled receiver backs up the queue and then the input.
// Reset: parser waits for a first header byte, queue and output empty,
// max_message_length returns to 65536. After a close event every
// later byte is accepted and dropped until reset.
module websocket_frame_receiver_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [wfr_pkg::DATA_W-1:0]  pwdata,
	output logic [wfr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  event_kind,
	output logic [7:0]                  payload_byte,
	output logic                        last_of_message,
	output logic [3:0]                  close_reason
);

	logic [31:0]   max_len_q;
	logic          push, pop, full, empty;
	wfr_pkg::cmd_t front_cmd, queue_cmd;
	logic          reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[wfr_pkg::ADDR_W-1] == wfr_pkg::REG_MAX_LEN);
	assign prdata  = reg_sel ? max_len_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= wfr_pkg::MAX_LEN_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_len_q <= pwdata;
		end
	end

	assign in_stall = full;

	wfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.full     (full),
		.max_len  (max_len_q),
		.push     (push),
		.cmd      (front_cmd)
	);

	wfr_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(wfr_pkg::cmd_t))
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_cmd),
		.pop     (pop),
		.rd_data (queue_cmd),
		.full    (full),
		.empty   (empty)
	);

	wfr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (queue_cmd),
		.empty           (empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_kind      (event_kind),
		.payload_byte    (payload_byte),
		.last_of_message (last_of_message),
		.close_reason    (close_reason)
	);

endmodule

// ----- dv/wfr_event_checker.sv -----
`timescale 1ns / 1ps

module wfr_event_checker
	import wfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        event_kind,
	input  logic [7:0]        payload_byte,
	input  logic              last_of_message,
	input  logic [3:0]        close_reason,
	output int                failures,
	output int                pending,
	output int                events_checked
);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
		logic [3:0] reason;
	} frame_event_t;

	frame_event_t awaited[$];

	logic [31:0] limit_len;
	phase_t      phase;
	logic        ping;
	logic [6:0]  len_code;
	logic [2:0]  len_bytes;
	logic [63:0] frame_len;
	logic [31:0] key;
	logic [63:0] remaining;
	logic [1:0]  key_pos;

	task automatic await_event(input logic [1:0] kind, input logic [7:0] data,
		input logic last, input logic [3:0] reason);
		frame_event_t ev;
		ev.kind = kind;
		ev.data = data;
		ev.last = last;
		ev.reason = reason;
		awaited.push_back(ev);
	endtask

	task automatic close_link(input logic [3:0] why);
		phase = PH_CLOSED;
		await_event(EV_CLOSE, 8'h00, 1'b0, why);
	endtask

	task automatic check_length();
		if (frame_len > {32'd0, limit_len}) begin
			close_link(RSN_TOO_LONG);
		end else begin
			key = '0;
			key_pos = '0;
			phase = PH_MASK;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [3:0] op;
		logic [7:0] kb;
		op = b[3:0] & OP_BITS[3:0];
		case (phase)
			PH_HDR0: begin
				if ((b & FIN_BIT) == 8'h00) close_link(RSN_FIN_CLEAR);
				else if ((b & RSV_BITS) != 8'h00) close_link(RSN_RESERVED);
				else if (op == OP_TEXT) begin
					ping = 1'b0;
					phase = PH_HDR1;
				end else if (op == OP_CLOSE) close_link(RSN_PEER);
				else if (op == OP_PING) begin
					ping = 1'b1;
					phase = PH_HDR1;
					await_event(EV_PONG, 8'h00, 1'b0, 4'h0);
				end else if (op == OP_PONG) close_link(RSN_PONG);
				else close_link(RSN_BAD_OP);
			end
			PH_HDR1: begin
				if ((b & MASK_BIT) == 8'h00) begin
					close_link(RSN_UNMASKED);
				end else begin
					len_code = b[6:0];
					frame_len = '0;
					if (len_code == LEN_EXT16) begin
						len_bytes = 3'd2;
						phase = PH_EXTLEN;
					end else if (len_code == LEN_EXT64) begin
						len_bytes = 3'd0;
						phase = PH_EXTLEN;
					end else if (len_code == 7'd0 && !ping) begin
						close_link(RSN_EMPTY);
					end else begin
						frame_len = {57'd0, len_code};
						check_length();
					end
				end
			end
			PH_EXTLEN: begin
				frame_len = {frame_len[55:0], b};
				len_bytes = len_bytes - 3'd1;
				if (len_bytes == 3'd0) begin
					if (frame_len == 64'd0) close_link(RSN_ZERO_EXT);
					else check_length();
				end
			end
			PH_MASK: begin
				key = {key[23:0], b};
				key_pos = key_pos + 2'd1;
				if (key_pos == 2'd0) begin
					remaining = frame_len;
					phase = (remaining == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				kb = key[8 * (3 - key_pos) +: 8];
				key_pos = key_pos + 2'd1;
				remaining = remaining - 64'd1;
				await_event(EV_PAYLOAD, b ^ kb, remaining == 64'd0, 4'h0);
				if (remaining == 64'd0) phase = PH_HDR0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_event_t want;
		if (!arst_n) begin
			limit_len = MAX_LEN_RESET;
			phase = PH_HDR0;
			ping = 1'b0;
			len_code = '0;
			len_bytes = '0;
			frame_len = '0;
			key = '0;
			remaining = '0;
			key_pos = '0;
			awaited.delete();
			failures = 0;
			pending = 0;
			events_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("unexpected event transfer: event_kind %0d", event_kind);
					failures++;
				end else begin
					want = awaited[0];
					awaited.delete(0);
					events_checked++;
					if (event_kind !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
						failures++;
					end
					if (payload_byte !== want.data) begin
						$error("payload_byte: expected %0h, got %0h", want.data, payload_byte);
						failures++;
					end
					if (last_of_message !== want.last) begin
						$error("last_of_message: expected %0d, got %0d", want.last,
							last_of_message);
						failures++;
					end
					if (close_reason !== want.reason) begin
						$error("close_reason: expected %0d, got %0d", want.reason, close_reason);
						failures++;
					end
				end
			end
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_MAX_LEN)
				limit_len = pwdata;
			if (in_valid && !in_stall)
				parse_byte(rx_byte);
			pending = awaited.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import wfr_pkg::*;

	typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

	localparam logic [ADDR_W-1:0] MAX_LEN_ADDR = ADDR_W'(4 * REG_MAX_LEN);
	localparam logic [ADDR_W-1:0] SPARE_ADDR   = 3'd4;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int NOISE_BYTES = 30;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        event_kind;
	logic [7:0]        payload_byte;
	logic              last_of_message;
	logic [3:0]        close_reason;

	int failures;
	int pending;
	int events_checked;

	logic        calm = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int          quiet = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned limits_used = 0;
	logic [3:0]  close_why = '0;

	websocket_frame_receiver_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.payload_byte(payload_byte),
		.last_of_message(last_of_message),
		.close_reason(close_reason)
	);

	wfr_event_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.payload_byte(payload_byte),
		.last_of_message(last_of_message),
		.close_reason(close_reason),
		.failures(failures),
		.pending(pending),
		.events_checked(events_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// receiver side: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 9);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic len_form_t pick_form(input logic [63:0] len);
		int r;
		r = $urandom_range(0, 9);
		if (len == 64'd0) return FORM_SHORT;
		if (len > 64'd65535) return FORM_EXT64;
		if (len > 64'd125) return (r < 7) ? FORM_EXT16 : FORM_EXT64;
		if (r < 6) return FORM_SHORT;
		return (r < 8) ? FORM_EXT16 : FORM_EXT64;
	endfunction

	task automatic send_length(input logic [63:0] len, input len_form_t form);
		int k;
		case (form)
			FORM_SHORT: send_byte(MASK_BIT | {1'b0, len[6:0]});
			FORM_EXT16: begin
				send_byte(MASK_BIT | {1'b0, LEN_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte(MASK_BIT | {1'b0, LEN_EXT64});
				for (k = 7; k >= 0; k--) send_byte(len[8 * k +: 8]);
			end
		endcase
	endtask

	task automatic send_frame(input bit as_ping, input int unsigned len, input len_form_t form,
		input bit extremes);
		int unsigned i;
		send_byte(FIN_BIT | {4'h0, as_ping ? OP_PING : OP_TEXT});
		send_length(64'(len), form);
		for (i = 0; i < 4; i++) send_byte(extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
		for (i = 0; i < len; i++) send_byte(extremes ? (i[1] ? 8'hFF : 8'h00) : 8'($urandom));
		frames_sent++;
	endtask

	task automatic random_frame(input logic [31:0] lim);
		bit          as_ping;
		int unsigned cap;
		int unsigned len;
		as_ping = (lim == 32'd0) || ($urandom_range(0, 99) < 15);
		cap = ($urandom_range(0, 19) == 0) ? 300 : 16;
		if (lim < cap) cap = lim;
		len = as_ping ? $urandom_range(0, cap) : $urandom_range(1, cap);
		send_frame(as_ping, len, pick_form(64'(len)), 1'b0);
	endtask

	task automatic run_phase(input logic [31:0] lim, input int unsigned nbytes);
		int unsigned stop_at;
		drain();
		reg_write(MAX_LEN_ADDR, lim);
		limits_used++;
		stop_at = bytes_sent + nbytes;
		while (bytes_sent < stop_at) random_frame(lim);
	endtask

	task automatic break_link(input logic [31:0] lim);
		logic [3:0]  op;
		logic [7:0]  hdr;
		logic [63:0] len;
		close_why = 4'($urandom_range(0, 8));
		hdr = FIN_BIT | {4'h0, $urandom_range(0, 1) ? OP_PING : OP_TEXT};
		case (close_why)
			RSN_FIN_CLEAR: send_byte(8'($urandom_range(0, 127)));
			RSN_RESERVED: send_byte(FIN_BIT | {1'b0, 3'($urandom_range(1, 7)), 4'($urandom)});
			RSN_PEER: send_byte(FIN_BIT | {4'h0, OP_CLOSE});
			RSN_PONG: send_byte(FIN_BIT | {4'h0, OP_PONG});
			RSN_BAD_OP: begin
				do op = 4'($urandom);
				while (op == OP_TEXT || op == OP_CLOSE || op == OP_PING || op == OP_PONG);
				send_byte(FIN_BIT | {4'h0, op});
			end
			RSN_UNMASKED: begin
				send_byte(hdr);
				send_byte(8'($urandom_range(0, 127)));
			end
			RSN_EMPTY: begin
				send_byte(FIN_BIT | {4'h0, OP_TEXT});
				send_byte(MASK_BIT);
			end
			RSN_ZERO_EXT: begin
				send_byte(hdr);
				send_length(64'd0, $urandom_range(0, 1) ? FORM_EXT16 : FORM_EXT64);
			end
			default: begin
				send_byte(hdr);
				if ($urandom_range(0, 2) == 0) begin
					len = {1'b1, 31'($urandom), 32'($urandom)};
					send_length(len, FORM_EXT64);
				end else begin
					len = 64'(lim) + 64'd1;
					send_length(len, pick_form(len));
				end
			end
		endcase
	endtask

	initial begin
		logic [31:0] fin_lim;
		int unsigned stop_at;
		int          r;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ping, ping with payload, text with all-zero/all-one key and data mixes
		send_frame(1'b1, 0, FORM_SHORT, 1'b1);
		send_frame(1'b1, 1, FORM_SHORT, 1'b1);
		send_frame(1'b0, 4, FORM_SHORT, 1'b1);

		stop_at = bytes_sent + 50;
		while (bytes_sent < stop_at) random_frame(MAX_LEN_RESET);

		run_phase(32'hFFFF_FFFF, 50);
		hold_req <= 1'b1;
		send_frame(1'b0, 126, FORM_EXT16, 1'b0);
		send_frame(1'b0, 20 + $urandom_range(0, 20), FORM_EXT64, 1'b0);

		drain();
		reg_write(SPARE_ADDR, 32'($urandom));

		run_phase(32'd0, 30);
		run_phase(32'd1, 30);
		calm <= 1'b1;
		run_phase(32'd5, 90);
		calm <= 1'b0;
		run_phase(32'($urandom_range(2, 200)), 50);
		run_phase(32'($urandom), 50);
		run_phase(MAX_LEN_RESET, 40);

		r = $urandom_range(0, 3);
		case (r)
			0: fin_lim = 32'd0;
			1: fin_lim = 32'($urandom_range(1, 124));
			2: fin_lim = 32'($urandom_range(126, 70000));
			default: fin_lim = 32'hFFFF_FFFF;
		endcase
		run_phase(fin_lim, 30);
		break_link(fin_lim);
		repeat (NOISE_BYTES) send_byte(8'($urandom));
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d bytes in %0d frames under %0d length limits, %0d events checked.",
			bytes_sent, frames_sent, limits_used, events_checked);
		$display("Link closed with reason %0d, then %0d bytes were dropped.", close_why,
			NOISE_BYTES);
		if (failures == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- websocket_frame_receiver_unit.f -----
+incdir+rtl
rtl/wfr_pkg.sv
rtl/wfr_front.sv
rtl/wfr_queue.sv
rtl/wfr_back.sv
rtl/websocket_frame_receiver_unit.sv
dv/wfr_event_checker.sv
dv/tb.sv
